[hw/rtl/msbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbp_pkg
// Shared widths, action codes and defaults for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package msbp_pkg;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 6;
  localparam int BYTE_W   = 8;
  localparam int TOTAL_W  = 9;
  localparam int ACC_W    = 64;

  // Most bits one write can append
  localparam logic [COUNT_W-1:0] MAX_BITS = 6'd32;
  // Pending bit count that triggers byte output on a write
  localparam logic [COUNT_W-1:0] EMIT_THRESHOLD = 6'd32;

  localparam int DEFAULT_BUFFER_BYTES = 256;

  typedef logic [ACTION_W-1:0] action_t;

  localparam action_t ACT_WRITE  = 2'd0;
  localparam action_t ACT_FINISH = 2'd1;
  localparam action_t ACT_CLEAR  = 2'd2;

endpackage

[hw/rtl/msb_first_bit_packer.sv]
`timescale 1ns / 1ps
// An accepted write that reaches 32 pending bits, or a finish, sends the sequencer to its emit state.
// Throughput: one byte per cycle while the output slot is free, from a shared extraction datapath;
// such a write emits all its whole bytes, a finish also its padded tail, other items emit nothing.
// in_ready stays low while the sequencer emits bytes; an output register holds the last
// byte so the next item can be accepted before it is taken.
// Synchronous active-low reset empties the accumulator, the counters and the output.
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs variable-length bit fields, most significant bit first, into bytes.
// ----------------------------------------------------------------------------
module msb_first_bit_packer #(
  parameter int BUFFER_BYTES = msbp_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [msbp_pkg::ACTION_W-1:0] in_action,
  input  logic [msbp_pkg::VALUE_W-1:0]  in_value,
  input  logic [msbp_pkg::COUNT_W-1:0]  in_bit_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [msbp_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_byte_valid,
  output logic                          out_last,
  output logic [msbp_pkg::TOTAL_W-1:0]  out_total_bytes
);
  import msbp_pkg::*;

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  // Buffer limit for the padded-byte check, and the counter ceiling
  localparam int            BUF_W     = 17;
  localparam logic [BUF_W-1:0] BUF_LIM = BUF_W'(BUFFER_BYTES);
  localparam logic [TOTAL_W-1:0] CNT_LIMIT =
    (BUFFER_BYTES < 511) ? TOTAL_W'(BUFFER_BYTES) : 9'd511;

  // Packer state
  logic               state_r, state_nxt;
  logic               fin_r, fin_nxt;        // current emit run belongs to a finish
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [COUNT_W-1:0] pend_r, pend_nxt;
  logic [TOTAL_W-1:0] cnt_r, cnt_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_bv_r, out_bv_nxt;
  logic               out_last_r, out_last_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;

  // Write datapath
  logic [COUNT_W-1:0] nbits;
  logic [ACC_W-1:0]   vmask;
  logic [ACC_W-1:0]   acc_wr;
  logic [COUNT_W-1:0] pend_wr;

  // Shared extraction datapath
  logic [COUNT_W-1:0] pend_dec;
  logic [BYTE_W-1:0]  byte_whole;
  logic [BYTE_W-1:0]  byte_pad;
  logic [3:0]         pad_sh;
  logic [TOTAL_W-1:0] cnt_inc;
  logic               have_whole;
  logic               room;
  logic               room_inc;
  logic               slot_free;
  logic               in_fire;
  logic               emit_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  // The output slot frees up when it is empty or being taken this cycle
  assign slot_free = !out_valid_r || out_ready;

  // Clamp the bit count, mask the value and shift it in below the older bits
  always_comb begin
    nbits   = (in_bit_count > MAX_BITS) ? MAX_BITS : in_bit_count;
    vmask   = {{(ACC_W-VALUE_W){1'b0}}, in_value} & ~({ACC_W{1'b1}} << nbits);
    acc_wr  = (acc_r << nbits) | vmask;
    pend_wr = pend_r + nbits;
  end

  // One byte per cycle while the output slot is free: oldest whole byte, or the zero-padded tail
  always_comb begin
    pend_dec   = pend_r - 6'd8;
    byte_whole = BYTE_W'(acc_r >> pend_dec);
    pad_sh     = 4'd8 - {1'b0, pend_r[2:0]};
    byte_pad   = BYTE_W'(acc_r[BYTE_W-1:0] << pad_sh);
    cnt_inc    = (cnt_r < CNT_LIMIT) ? cnt_r + 9'd1 : cnt_r;
    have_whole = (pend_r[COUNT_W-1:3] != '0);
    room       = {{(BUF_W-TOTAL_W){1'b0}}, cnt_r} < BUF_LIM;
    room_inc   = {{(BUF_W-TOTAL_W){1'b0}}, cnt_inc} < BUF_LIM;
  end

  always_comb begin
    state_nxt     = state_r;
    fin_nxt       = fin_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_last_nxt  = out_last_r;
    out_total_nxt = out_total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    emit_last     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_action)
            ACT_WRITE: begin
              acc_nxt  = acc_wr;
              pend_nxt = pend_wr;
              fin_nxt  = 1'b0;
              if (pend_wr >= EMIT_THRESHOLD) begin
                state_nxt = ST_EMIT;
              end
            end
            ACT_FINISH: begin
              fin_nxt   = 1'b1;
              state_nxt = ST_EMIT;
            end
            ACT_CLEAR: begin
              acc_nxt  = '0;
              pend_nxt = '0;
              cnt_nxt  = '0;
            end
            default: begin
              // Unused action: drop the item, keep the state
            end
          endcase
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          priority if (have_whole) begin
            // Whole byte; last once no whole byte nor padded tail follows
            pend_nxt     = pend_dec;
            cnt_nxt      = cnt_inc;
            out_byte_nxt = byte_whole;
            out_bv_nxt   = 1'b1;
            emit_last    = (pend_dec[COUNT_W-1:3] == '0) &&
                           (!fin_r || (pend_dec == '0) || !room_inc);
            out_total_nxt = (fin_r && emit_last) ? cnt_inc : '0;
          end else if ((pend_r != '0) && room) begin
            // Padded tail of a finish
            cnt_nxt       = cnt_inc;
            out_byte_nxt  = byte_pad;
            out_bv_nxt    = 1'b1;
            emit_last     = 1'b1;
            out_total_nxt = cnt_inc;
          end else begin
            // Finish that has no byte to give
            out_byte_nxt  = '0;
            out_bv_nxt    = 1'b0;
            emit_last     = 1'b1;
            out_total_nxt = cnt_r;
          end
          out_last_nxt = emit_last;

          if (emit_last) begin
            state_nxt = ST_IDLE;
            if (fin_r) begin
              acc_nxt  = '0;
              pend_nxt = '0;
              cnt_nxt  = '0;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fin_r       <= 1'b0;
      acc_r       <= '0;
      pend_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_r       <= fin_nxt;
      acc_r       <= acc_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the output register needs no reset
  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_bv_r    <= out_bv_nxt;
    out_last_r  <= out_last_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_valid  = out_bv_r;
  assign out_last        = out_last_r;
  assign out_total_bytes = out_total_r;

endmodule

[hw/rtl/msbp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbp_checker
// Port-level checks for the MSB-first bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module msbp_checker #(
  parameter int BUFFER_BYTES = msbp_pkg::DEFAULT_BUFFER_BYTES
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [msbp_pkg::ACTION_W-1:0] in_action,
  input logic [msbp_pkg::VALUE_W-1:0]  in_value,
  input logic [msbp_pkg::COUNT_W-1:0]  in_bit_count,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [msbp_pkg::BYTE_W-1:0]   out_byte,
  input logic                          out_byte_valid,
  input logic                          out_last,
  input logic [msbp_pkg::TOTAL_W-1:0]  out_total_bytes
);
  import msbp_pkg::*;

  localparam logic [TOTAL_W-1:0] CNT_LIMIT =
    (BUFFER_BYTES < 511) ? TOTAL_W'(BUFFER_BYTES) : 9'd511;

  // Hold a waiting input item
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_action) &&
      $stable(in_value) && $stable(in_bit_count))
    else $error("waiting input item changed");

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_byte_valid) && $stable(out_last) && $stable(out_total_bytes))
    else $error("stalled output item changed");

  // An empty finish item is always the last one, with a zero byte
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last && (out_byte == '0))
    else $error("empty item not last or byte not zero");

  // Byte total appears only on the last item
  a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_total_bytes == '0)
    else $error("byte total on a non-last item");

  // Byte total never passes the counter ceiling
  a_total_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_total_bytes <= CNT_LIMIT)
    else $error("byte total above ceiling");

endmodule

bind msb_first_bit_packer msbp_checker #(.BUFFER_BYTES(BUFFER_BYTES)) u_msbp_checker (.*);

[tb/tb_msb_first_bit_packer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_msb_first_bit_packer
// Self-checking bench for the MSB-first bit packer: a queued driver offers
// write, finish, clear and unused items, a bit-level predictor builds the byte
// stream each accepted item should produce, and a monitor checks every result.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_packer;

  import msbp_pkg::*;

  localparam int          BUF_BYTES   = DEFAULT_BUFFER_BYTES;
  localparam int          COUNT_CAP   = (BUF_BYTES < 511) ? BUF_BYTES : 511;
  localparam int          ITEM_TARGET = 460;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          GAP_PCT     = 22;
  localparam int          HOLD_CYCLES = 300;
  localparam action_t     ACT_UNUSED  = 2'd3;

  typedef struct packed {
    action_t              action;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   bit_count;
  } pack_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    data;
    logic                 has_byte;
    logic                 last;
    logic [TOTAL_W-1:0]   total;
  } packed_byte_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 rst_seen     = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [ACTION_W-1:0]  in_action    = ACT_WRITE;
  logic [VALUE_W-1:0]   in_value     = '0;
  logic [COUNT_W-1:0]   in_bit_count = '0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_byte_valid;
  logic                 out_last;
  logic [TOTAL_W-1:0]   out_total_bytes;

  // Items waiting to be offered, and the bytes the block still owes us
  pack_req_t            pending_items[$];
  packed_byte_t         expected_bytes[$];

  // Predictor state: pending bits sit in the low end of acc_bits
  logic [ACC_W-1:0]     acc_bits  = '0;
  int unsigned          pend_bits = 0;
  int unsigned          emitted   = 0;

  int                   planned_items  = 0;
  int                   issued         = 0;
  int                   acc_count      = 0;
  int                   cycle_count    = 0;
  int                   mismatches     = 0;
  int                   bytes_checked  = 0;
  int                   n_writes       = 0;
  int                   n_finishes     = 0;
  int                   n_clears       = 0;
  int                   n_unused       = 0;
  int                   dropped_pads   = 0;
  int                   hold_left      = 0;
  logic                 hold_done      = 1'b0;

  // Window of accepted items with no idling on either side
  wire calm_window = (acc_count >= 250) && (acc_count < 330);

  msb_first_bit_packer #(
    .BUFFER_BYTES(BUF_BYTES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_value       (in_value),
    .in_bit_count   (in_bit_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_total_bytes(out_total_bytes)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void count_byte();
    if (emitted < COUNT_CAP) begin
      emitted++;
    end
  endfunction

  function automatic void make_empty();
    acc_bits  = '0;
    pend_bits = 0;
    emitted   = 0;
  endfunction

  // Advance the predicted state by one item and queue the bytes it produces
  task automatic pack_item(input pack_req_t req);
    int unsigned   n;
    int unsigned   nbytes;
    logic [63:0]   shifted;
    packed_byte_t  batch[$];
    case (req.action)
      ACT_WRITE: begin
        n_writes++;
        // Oversized counts clamp to a full 32-bit field
        n = (req.bit_count > MAX_BITS) ? int'(MAX_BITS) : int'(req.bit_count);
        acc_bits = (acc_bits << n) | ({32'd0, req.value} & ((64'd1 << n) - 64'd1));
        pend_bits += n;
        // Below threshold nothing comes out; otherwise drain all whole bytes
        if (pend_bits >= EMIT_THRESHOLD) begin
          nbytes = pend_bits >> 3;
          for (int k = 0; k < nbytes; k++) begin
            shifted = acc_bits >> (pend_bits - 8 * (k + 1));
            batch.push_back('{shifted[7:0], 1'b1, (k + 1 == nbytes), 9'd0});
            count_byte();
          end
          pend_bits &= 7;
        end
      end
      ACT_FINISH: begin
        n_finishes++;
        while (pend_bits >= 8) begin
          pend_bits -= 8;
          shifted = acc_bits >> pend_bits;
          batch.push_back('{shifted[7:0], 1'b1, 1'b0, 9'd0});
          count_byte();
        end
        // Pad the leftover bits with zeros, unless the buffer is already full
        if (pend_bits > 0 && emitted < BUF_BYTES) begin
          shifted = acc_bits << (8 - pend_bits);
          batch.push_back('{shifted[7:0], 1'b1, 1'b0, 9'd0});
          count_byte();
        end else if (pend_bits > 0) begin
          dropped_pads++;
        end
        // A finish with no byte still reports once, with the count
        if (batch.size() == 0) begin
          batch.push_back('{8'h00, 1'b0, 1'b0, 9'd0});
        end
        batch[$].last  = 1'b1;
        batch[$].total = 9'(emitted);
        make_empty();
      end
      ACT_CLEAR: begin
        n_clears++;
        make_empty();
      end
      default: begin
        n_unused++;
      end
    endcase
    foreach (batch[i]) begin
      expected_bytes.push_back(batch[i]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------
  function automatic void plan(input action_t act, input logic [31:0] val,
                               input logic [5:0] cnt);
    pending_items.push_back('{act, val, cnt});
  endfunction

  function automatic logic [5:0] pick_count();
    // Mostly legal widths, now and then an oversized one
    if ($urandom_range(99) < 10) begin
      return 6'($urandom_range(63, 33));
    end
    return 6'($urandom_range(32, 0));
  endfunction

  // Random write burst of n items, closed by a finish or a clear
  function automatic void plan_stream(input int n, input logic end_with_clear);
    for (int i = 0; i < n; i++) begin
      plan(ACT_WRITE, $urandom, pick_count());
    end
    plan(end_with_clear ? ACT_CLEAR : ACT_FINISH, $urandom, 6'($urandom));
  endfunction

  initial begin
    int    kind;
    logic  did_fill_exact;
    logic  did_fill_over;
    did_fill_exact = 1'b0;
    did_fill_over  = 1'b0;

    // Directed part: extremes, each action, and the corner cases
    plan(ACT_WRITE,  32'hFFFF_FFFF, 6'd0);   // zero-width write
    plan(ACT_FINISH, 32'h0,         6'd0);   // empty finish, count 0
    plan(ACT_WRITE,  32'hFFFF_FFFF, 6'd32);  // exactly at threshold
    plan(ACT_WRITE,  32'h0000_0001, 6'd1);
    plan(ACT_FINISH, 32'hFFFF_FFFF, 6'd63);  // single padded byte
    plan(ACT_WRITE,  32'hA5A5_A5A5, 6'd63);  // oversized count clamps
    plan(ACT_WRITE,  32'h0000_007F, 6'd7);
    plan(ACT_WRITE,  32'h0000_0000, 6'd32);  // 39 pending, keep 7
    plan(ACT_FINISH, 32'h0,         6'd0);
    plan(ACT_WRITE,  32'hDEAD_BEEF, 6'd20);
    plan(ACT_CLEAR,  32'hFFFF_FFFF, 6'd63);  // drop pending bits
    plan(ACT_FINISH, 32'h0,         6'd0);
    plan(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63);  // ignored action
    plan(ACT_WRITE,  32'h1234_5678, 6'd31);  // below threshold
    plan(ACT_FINISH, 32'h0,         6'd0);   // whole bytes plus a pad
    plan(ACT_WRITE,  32'h1234_5678, 6'd8);
    plan(ACT_FINISH, 32'h0,         6'd0);   // one whole byte, no pad
    plan(ACT_WRITE,  32'h8000_0000, 6'd33);
    plan(ACT_WRITE,  32'hFFFF_FFFF, 6'd31);
    plan(ACT_WRITE,  32'hFFFF_FFFF, 6'd32);  // 63 pending, seven bytes
    plan(ACT_FINISH, 32'h0,         6'd0);
    plan(ACT_CLEAR,  32'h0,         6'd0);   // clear while already empty

    // Random part
    while (pending_items.size() < ITEM_TARGET) begin
      if (!did_fill_exact && pending_items.size() >= 150) begin
        // Fill the buffer to exactly its size, then finish with a stub:
        // the pad is dropped and the finish reports nothing but the count
        did_fill_exact = 1'b1;
        for (int i = 0; i < BUF_BYTES / 4; i++) begin
          plan(ACT_WRITE, $urandom, 6'd32);
        end
        plan(ACT_WRITE, $urandom, 6'($urandom_range(7, 1)));
        plan(ACT_FINISH, $urandom, 6'($urandom));
      end else if (!did_fill_over && pending_items.size() >= 330) begin
        // Run around and often past the buffer size so the counter can saturate
        did_fill_over = 1'b1;
        for (int i = 0; i < 80; i++) begin
          plan(ACT_WRITE, $urandom, 6'($urandom_range(32, 24)));
        end
        plan(ACT_WRITE, $urandom, 6'($urandom_range(7, 1)));
        plan(ACT_FINISH, $urandom, 6'($urandom));
      end else begin
        kind = $urandom_range(99);
        if (kind < 60) begin
          plan_stream($urandom_range(12, 1), 1'b0);
        end else if (kind < 70) begin
          plan_stream($urandom_range(6, 1), 1'b1);
        end else if (kind < 85) begin
          // Long-field writes that carry bits across item boundaries
          for (int i = 0; i < $urandom_range(4, 1); i++) begin
            plan(ACT_WRITE, $urandom, 6'($urandom_range(32, 25)));
          end
        end else begin
          // Noise: unused actions, stray finishes and clears, empty writes
          case ($urandom_range(3))
            0: plan(ACT_UNUSED, $urandom, 6'($urandom));
            1: plan(ACT_FINISH, $urandom, 6'($urandom));
            2: plan(ACT_CLEAR,  $urandom, 6'($urandom));
            default: plan(ACT_WRITE, $urandom, 6'd0);
          endcase
        end
      end
    end
    plan(ACT_FINISH, 32'h0, 6'd0);
    planned_items = pending_items.size();

    // Hold reset, release it at a falling edge
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Wait for every item to be taken and every byte to come back
    while (!(acc_count == planned_items && expected_bytes.size() == 0)) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Covered %0d items: %0d writes, %0d finishes, %0d clears, %0d unused.",
             planned_items, n_writes, n_finishes, n_clears, n_unused);
    $display("Checked %0d results; %0d padded bytes dropped on a full buffer.",
             bytes_checked, dropped_pads);
    if (mismatches == 0) begin
      $display("msb_first_bit_packer test passed");
    end else begin
      $display("msb_first_bit_packer test failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: present the next item at the falling edge once the last is taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_items
    pack_req_t req;
    if (rst_seen && acc_count == issued) begin
      if (pending_items.size() > 0 && (calm_window || $urandom_range(99) >= GAP_PCT)) begin
        req = pending_items.pop_front();
        in_valid     <= 1'b1;
        in_action    <= req.action;
        in_value     <= req.value;
        in_bit_count <= req.bit_count;
        issued       <= issued + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off so the block backs up
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_seen) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && acc_count >= 60) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm_window || ($urandom_range(99) >= GAP_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results first, then predict for the item taken this edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    packed_byte_t want;
    rst_seen <= rst_n;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        bytes_checked <= bytes_checked + 1;
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: out_byte %0h with nothing outstanding", out_byte);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, actual %0h", want.data, out_byte);
            mismatches++;
          end
          if (out_byte_valid !== want.has_byte) begin
            $error("out_byte_valid: expected %0b, actual %0b", want.has_byte,
                   out_byte_valid);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, out_last);
            mismatches++;
          end
          if (out_total_bytes !== want.total) begin
            $error("out_total_bytes: expected %0d, actual %0d", want.total,
                   out_total_bytes);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pack_item('{in_action, in_value, in_bit_count});
        acc_count <= acc_count + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d items taken, %0d results outstanding",
               cycle_count, acc_count, expected_bytes.size());
      $display("msb_first_bit_packer test failed");
      $finish;
    end
  end

endmodule
